>>> hdl/mqpp_pkg.sv
package mqpp_pkg;

    // Command codes of an input word
    localparam logic [1:0] CMD_ACCESS = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_EVICT  = 2'd2;
    localparam logic [1:0] CMD_PEEK   = 2'd3;

    // Outcome codes of a result word
    localparam logic [1:0] OUT_NEW   = 2'd0;
    localparam logic [1:0] OUT_TAIL  = 2'd1;
    localparam logic [1:0] OUT_PROM  = 2'd2;
    localparam logic [1:0] OUT_EMPTY = 2'd3;

    localparam logic [10:0] COUNT_MAX = 11'd2047;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  page;
        logic [2:0]  level;
        logic [15:0] access_count;
    } req_t;

    typedef struct packed {
        logic [2:0]  new_level;
        logic [9:0]  head_page;
        logic [10:0] queue_size;
        logic [1:0]  outcome;
    } res_t;

    // Datapath operations issued by the controller, one per cycle
    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_SRCH_RD,
        DP_SRCH_ADV,
        DP_FND_RD,
        DP_FND_UNLINK,
        DP_FND_CLR,
        DP_APP_CLR,
        DP_APP_HEAD_SET,
        DP_APP_RD_CUR,
        DP_APP_STEP,
        DP_APP_LINK,
        DP_EV_RD,
        DP_EV_POP,
        DP_PEEK,
        DP_EMPTY,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       page_ok;
        logic       cur_zero;
        logic       cur_hit;
        logic       steps_max;
        logic       rd_zero;
        logic       clr_last;
        logic       qhead_zero;
    } dp_stat_t;

endpackage

>>> hdl/mqpp_dp.sv
module mqpp_dp
    import mqpp_pkg::*;
#(
    parameter int PAGES      = 1024,
    parameter int LEVELS     = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     request,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output res_t     result
);

    localparam int AW = $clog2(PAGES);
    localparam int LW = $clog2(LEVELS);
    localparam int SW = $clog2(PAGES + 1);
    localparam logic [15:0] CMASK =
        (COUNT_BITS >= 16) ? 16'hFFFF : 16'((1 << COUNT_BITS) - 1);

    logic [AW-1:0] mem [PAGES];
    logic [AW-1:0] rd_data_reg;

    logic [1:0]    cmd_reg;
    logic [AW-1:0] page_reg;
    logic          page_ok_reg;
    logic          promote_reg;
    logic [LW-1:0] q_reg;
    logic [LW-1:0] tq_reg;
    logic [AW-1:0] cur_reg;
    logic [AW-1:0] prev_reg;
    logic [SW-1:0] steps_reg;
    logic [AW-1:0] head_out_reg;
    logic [1:0]    outcome_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] head_reg  [LEVELS];
    logic [10:0]   count_reg [LEVELS];
    res_t          result_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [LW-1:0] q_next;
    logic          page_ok_next;
    logic [16:0]   thr;
    logic [15:0]   acc_m;
    logic          promote_next;

    // Clamp the level and work out the promotion test at load time
    always_comb
    begin
        if (32'(request.level) >= LEVELS)
            q_next = LW'(LEVELS - 1);
        else
            q_next = LW'(request.level);
        page_ok_next = (request.page != 10'd0) && (32'(request.page) < PAGES);
        acc_m        = request.access_count & CMASK;
        thr          = (17'd2 << q_next) - 17'd1;
        promote_next = ({1'b0, acc_m} > thr) && (32'(q_next) < LEVELS - 1);
    end

    // Memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = page_reg;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = cur_reg;
        case (cmd.op)
            DP_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
            end
            DP_SRCH_RD, DP_APP_RD_CUR:
            begin
                rd_en = 1'b1;
            end
            DP_FND_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = page_reg;
            end
            DP_FND_UNLINK:
            begin
                wr_en   = (prev_reg != '0);
                wr_addr = prev_reg;
                wr_data = rd_data_reg;
            end
            DP_FND_CLR, DP_APP_CLR:
            begin
                wr_en = 1'b1;
            end
            DP_APP_STEP:
            begin
                rd_en   = 1'b1;
                rd_addr = rd_data_reg;
            end
            DP_APP_LINK:
            begin
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = page_reg;
            end
            DP_EV_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = head_reg[q_reg];
            end
            DP_EV_POP:
            begin
                wr_en   = 1'b1;
                wr_addr = head_out_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                cmd_reg      <= request.command;
                page_reg     <= AW'(request.page);
                page_ok_reg  <= page_ok_next;
                promote_reg  <= promote_next;
                q_reg        <= q_next;
                tq_reg       <= q_next;
                cur_reg      <= head_reg[q_next];
                prev_reg     <= '0;
                steps_reg    <= '0;
                head_out_reg <= '0;
                outcome_reg  <= OUT_NEW;
            end
            DP_SRCH_ADV:
            begin
                prev_reg  <= cur_reg;
                cur_reg   <= rd_data_reg;
                steps_reg <= steps_reg + 1'b1;
            end
            DP_FND_CLR:
            begin
                tq_reg      <= promote_reg ? q_reg + 1'b1 : q_reg;
                outcome_reg <= promote_reg ? OUT_PROM : OUT_TAIL;
            end
            DP_APP_CLR:
            begin
                cur_reg   <= head_reg[tq_reg];
                steps_reg <= '0;
            end
            DP_APP_STEP:
            begin
                cur_reg   <= rd_data_reg;
                steps_reg <= steps_reg + 1'b1;
            end
            DP_EV_RD, DP_PEEK:
            begin
                head_out_reg <= head_reg[q_reg];
            end
            DP_EMPTY:
            begin
                outcome_reg <= OUT_EMPTY;
            end
            DP_RESULT:
            begin
                result_reg.new_level  <= 3'(tq_reg);
                result_reg.head_page  <= 10'(head_out_reg);
                result_reg.queue_size <= count_reg[tq_reg];
                result_reg.outcome    <= outcome_reg;
            end
            default:
            begin
                cur_reg <= cur_reg;
            end
        endcase
    end

    // Queue heads, counts and the clear sweep pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                DP_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                DP_FND_UNLINK:
                begin
                    if (prev_reg == '0)
                        head_reg[q_reg] <= rd_data_reg;
                end
                DP_FND_CLR:
                begin
                    if (count_reg[q_reg] != '0)
                        count_reg[q_reg] <= count_reg[q_reg] - 1'b1;
                end
                DP_APP_HEAD_SET:
                begin
                    head_reg[tq_reg] <= page_reg;
                    if (count_reg[tq_reg] != COUNT_MAX)
                        count_reg[tq_reg] <= count_reg[tq_reg] + 1'b1;
                end
                DP_APP_LINK:
                begin
                    if (count_reg[tq_reg] != COUNT_MAX)
                        count_reg[tq_reg] <= count_reg[tq_reg] + 1'b1;
                end
                DP_EV_POP:
                begin
                    head_reg[q_reg] <= rd_data_reg;
                    if (count_reg[q_reg] != '0)
                        count_reg[q_reg] <= count_reg[q_reg] - 1'b1;
                end
                default:
                begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        stat.command    = cmd_reg;
        stat.page_ok    = page_ok_reg;
        stat.cur_zero   = (cur_reg == '0);
        stat.cur_hit    = (cur_reg == page_reg);
        stat.steps_max  = (steps_reg == SW'(PAGES));
        stat.rd_zero    = (rd_data_reg == '0);
        stat.clr_last   = (clr_reg == AW'(PAGES - 1));
        stat.qhead_zero = (head_reg[q_reg] == '0);
    end

    assign result = result_reg;

endmodule

>>> hdl/mqpp_ctrl.sv
module mqpp_ctrl
    import mqpp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SRCH,
        ST_SRCH_W,
        ST_FND_W,
        ST_FND_CLR,
        ST_APP_CLR,
        ST_APP_HEAD,
        ST_APP_W,
        ST_EV_W,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = DP_CLEAR;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (stat.command)
                    CMD_ACCESS:
                        state_next = stat.page_ok ? ST_SRCH : ST_DONE;
                    CMD_APPEND:
                        state_next = stat.page_ok ? ST_APP_CLR : ST_DONE;
                    CMD_EVICT:
                    begin
                        if (stat.qhead_zero)
                        begin
                            cmd.op     = DP_EMPTY;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.op     = DP_EV_RD;
                            state_next = ST_EV_W;
                        end
                    end
                    default:
                    begin
                        cmd.op     = stat.qhead_zero ? DP_EMPTY : DP_PEEK;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SRCH:
            begin
                if (stat.cur_zero || stat.steps_max)
                    state_next = ST_APP_CLR;
                else if (stat.cur_hit)
                begin
                    cmd.op     = DP_FND_RD;
                    state_next = ST_FND_W;
                end
                else
                begin
                    cmd.op     = DP_SRCH_RD;
                    state_next = ST_SRCH_W;
                end
            end
            ST_SRCH_W:
            begin
                cmd.op     = DP_SRCH_ADV;
                state_next = ST_SRCH;
            end
            ST_FND_W:
            begin
                cmd.op     = DP_FND_UNLINK;
                state_next = ST_FND_CLR;
            end
            ST_FND_CLR:
            begin
                cmd.op     = DP_FND_CLR;
                state_next = ST_APP_CLR;
            end
            ST_APP_CLR:
            begin
                cmd.op     = DP_APP_CLR;
                state_next = ST_APP_HEAD;
            end
            ST_APP_HEAD:
            begin
                if (stat.cur_zero)
                begin
                    cmd.op     = DP_APP_HEAD_SET;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = DP_APP_RD_CUR;
                    state_next = ST_APP_W;
                end
            end
            ST_APP_W:
            begin
                if (stat.rd_zero || stat.steps_max)
                begin
                    cmd.op     = DP_APP_LINK;
                    state_next = ST_DONE;
                end
                else
                    cmd.op = DP_APP_STEP;
            end
            ST_EV_W:
            begin
                cmd.op     = DP_EV_POP;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.op     = DP_RESULT;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DONE);
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

>>> hdl/multi_queue_page_promotion_core.sv
// Peek and rejected words go through load, dispatch and result only; list work goes longer:
//   each search step passes ST_SRCH and ST_SRCH_W, each tail-walk step ST_APP_W, on the single link-memory read port.
// Throughput: one word at a time; start is taken again once busy drops.
// Reset: queues empty; busy stays high while the link memory is swept
//   to zero. The receiver cannot stall: done marks a result for exactly one cycle.
module multi_queue_page_promotion_core
    import mqpp_pkg::*;
#(
    parameter int PAGES      = 1024,
    parameter int LEVELS     = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output res_t result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each command: search, unlink, append walk, pop, peek
    mqpp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !busy),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Hold link memory, queue heads, counts and the result word
    mqpp_dp #(
        .PAGES      (PAGES),
        .LEVELS     (LEVELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule

>>> hdl/mqpp_chk.sv
module mqpp_chk
    import mqpp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input res_t result
);

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.outcome == OUT_EMPTY |-> result.head_page == 10'd0)
        else $error("empty queue returned a head page");

    a_prom_level: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.outcome == OUT_PROM |-> result.new_level != 3'd0)
        else $error("promotion landed in the lowest queue");

endmodule

bind multi_queue_page_promotion_core mqpp_chk u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
